// File: sv/cbn_pkg.sv
// ----------------------------------------------------------------------------
// cbn_pkg
// Shared types and constants of the channel batch normaliser.
// ----------------------------------------------------------------------------
package cbn_pkg;

	localparam int MAX_ELEMENTS = 4096;
	localparam int MAX_CHANNELS = 256;
	localparam int ADDR_W       = 12;   // store address
	localparam int CNT_W        = 13;   // element count, holds MAX_ELEMENTS
	localparam int CH_W         = 8;    // channel index
	localparam int CHC_W        = 9;    // channel count register
	localparam int DIV_W        = 45;   // divider dividend and quotient
	localparam int DVS_W        = 16;   // divider divisor
	localparam int SQ_W         = 34;   // root radicand
	localparam int ROOT_W       = 17;   // root result
	localparam int CFG_W        = 16;
	localparam int CFG_IDX_W    = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ELEMENT_COUNT     = 3'd0,
		CFG_CHANNEL_COUNT     = 3'd1,
		CFG_SCALE_GAMMA       = 3'd2,
		CFG_SHIFT_BETA        = 3'd3,
		CFG_STABILITY_EPSILON = 3'd4
	} cfg_idx_t;

	// command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic signed [15:0] sample;
	} item_t;

	typedef struct packed {
		logic signed [15:0] norm_value;
		logic               channel_last;
		logic [CH_W-1:0]    channel_index;
	} result_t;

	// request to the shared divider
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

endpackage

// File: sv/cbn_div.sv
// ----------------------------------------------------------------------------
// cbn_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbn_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cbn_pkg::div_req_t      req,
	output logic                   done,
	output logic [cbn_pkg::DIV_W-1:0] quotient
);

	logic                        busy_q;
	logic                        done_q;
	logic [5:0]                  cnt_q;
	logic [cbn_pkg::DIV_W-1:0]   dvd_q;
	logic [cbn_pkg::DVS_W:0]     rem_q;
	logic [cbn_pkg::DVS_W-1:0]   dvs_q;
	logic [cbn_pkg::DVS_W:0]     rem_sh;
	logic                        ge;

	// trial subtract of the shifted remainder
	assign rem_sh = {rem_q[cbn_pkg::DVS_W-1:0], dvd_q[cbn_pkg::DIV_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(cbn_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
			dvd_q <= {dvd_q[cbn_pkg::DIV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// File: sv/cbn_sqrt.sv
// ----------------------------------------------------------------------------
// cbn_sqrt
// Integer square root, digit by digit, one root bit per cycle.
// ----------------------------------------------------------------------------
module cbn_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cbn_pkg::SQ_W-1:0]   radicand,
	output logic                       done,
	output logic [cbn_pkg::ROOT_W-1:0] root
);

	logic                        busy_q;
	logic                        done_q;
	logic [4:0]                  cnt_q;
	logic [cbn_pkg::SQ_W-1:0]    rad_q;
	logic [cbn_pkg::ROOT_W+1:0]  rem_q;
	logic [cbn_pkg::ROOT_W-1:0]  root_q;
	logic [cbn_pkg::ROOT_W+1:0]  rem_sh;
	logic [cbn_pkg::ROOT_W+1:0]  trial;
	logic                        ge;

	// bring down two radicand bits and try root*4+1
	assign rem_sh = {rem_q[cbn_pkg::ROOT_W-1:0], rad_q[cbn_pkg::SQ_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(cbn_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[cbn_pkg::ROOT_W-2:0], ge};
			rad_q  <= {rad_q[cbn_pkg::SQ_W-3:0], 2'b00};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: sv/channel_batch_normalizer.sv
// ----------------------------------------------------------------------------
// channel_batch_normalizer
// Per-channel batch normalisation in fixed point with a shared divider.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken when start is high and busy is low. cmd 0 loads one Q8.8
// sample of the current channel. The load that completes the channel starts
// the statistics pass: mean division, a variance walk over the store (read,
// difference, square and accumulate for each element), variance division
// and square root, during which busy is high. Loads while results are
// pending are dropped. cmd 1 then returns one normalised element per beat;
// the result beat follows the read once the bit-serial divider has formed
// gamma*(x-mean)/std, or without a division when the deviation is zero. The
// result appears on result for one cycle with done high and cannot be held
// off. A read with nothing pending gives no beat.
// Configuration is to be written through cfg_we/cfg_index/cfg_data only
// while idle; the block does not enforce this. Reset clears the control
// state and loads the register defaults; the sample store is not cleared
// and needs no clearing pass.
// ----------------------------------------------------------------------------
module channel_batch_normalizer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  cbn_pkg::item_t                 item,
	output logic                           done,
	output cbn_pkg::result_t               result,
	input  logic                           cfg_we,
	input  logic [cbn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbn_pkg::CFG_W-1:0]      cfg_data
);

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_MEAN = 14'b00000000000010,
		S_WRD  = 14'b00000000000100,
		S_WDIF = 14'b00000000001000,
		S_WSQ  = 14'b00000000010000,
		S_WACC = 14'b00000000100000,
		S_VAR  = 14'b00000001000000,
		S_SQRT = 14'b00000010000000,
		S_RRD  = 14'b00000100000000,
		S_RDIF = 14'b00001000000000,
		S_RMUL = 14'b00010000000000,
		S_RABS = 14'b00100000000000,
		S_RDIV = 14'b01000000000000,
		S_ROUT = 14'b10000000000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [cbn_pkg::CNT_W-1:0]  elem_q;
	logic [cbn_pkg::CHC_W-1:0]  chan_q;
	logic signed [15:0]         gamma_q;
	logic signed [15:0]         beta_q;
	logic [15:0]                eps_q;

	// channel state
	logic [cbn_pkg::CNT_W-1:0]  load_pos_q;
	logic [cbn_pkg::CNT_W-1:0]  read_pos_q;
	logic [cbn_pkg::CNT_W-1:0]  cnt_q;
	logic [cbn_pkg::CNT_W-1:0]  idx_q;
	logic signed [28:0]         sum_q;
	logic signed [15:0]         mean_q;
	logic [15:0]                std_q;
	logic                       pending_q;
	logic [cbn_pkg::CH_W-1:0]   chan_idx_q;
	logic [cbn_pkg::DIV_W-1:0]  sq_q;
	logic signed [16:0]         diff_q;
	logic signed [33:0]         prod_q;
	logic                       neg_q;

	// store
	logic [15:0]                mem [cbn_pkg::MAX_ELEMENTS];
	logic [cbn_pkg::ADDR_W-1:0] addr_q;
	logic [15:0]                rdata_q;

	// shared units
	cbn_pkg::div_req_t          div_req_q;
	logic                       div_done;
	logic [cbn_pkg::DIV_W-1:0]  div_quot;
	logic                       sqrt_start_q;
	logic [cbn_pkg::SQ_W-1:0]   sqrt_rad_q;
	logic                       sqrt_done;
	logic [cbn_pkg::ROOT_W-1:0] sqrt_root;

	logic                       done_q;
	cbn_pkg::result_t           result_q;

	// effective counts
	logic [cbn_pkg::CNT_W-1:0]  eff_elem;
	logic [cbn_pkg::CHC_W-1:0]  eff_chan;
	logic                       accept;
	logic [cbn_pkg::CNT_W-1:0]  load_next;
	logic [cbn_pkg::CNT_W-1:0]  idx_next;
	logic [cbn_pkg::CNT_W-1:0]  read_next;
	logic [cbn_pkg::CH_W-1:0]   chan_next;
	logic signed [28:0]         sum_next;
	logic [16:0]                mean_mag;
	logic signed [16:0]         mean_ext;
	logic signed [16:0]         mul_a;
	logic signed [33:0]         prod_abs;
	logic signed [33:0]         quo_s;
	logic signed [34:0]         r_full;
	logic signed [15:0]         r_sat;

	assign eff_elem = (elem_q == '0) ? cbn_pkg::CNT_W'(1) :
	                  (elem_q > cbn_pkg::CNT_W'(cbn_pkg::MAX_ELEMENTS)) ?
	                  cbn_pkg::CNT_W'(cbn_pkg::MAX_ELEMENTS) : elem_q;
	assign eff_chan = (chan_q == '0) ? cbn_pkg::CHC_W'(1) :
	                  (chan_q > cbn_pkg::CHC_W'(cbn_pkg::MAX_CHANNELS)) ?
	                  cbn_pkg::CHC_W'(cbn_pkg::MAX_CHANNELS) : chan_q;

	assign accept    = start && (state_q == S_IDLE);
	assign load_next = load_pos_q + cbn_pkg::CNT_W'(1);
	assign idx_next  = idx_q + cbn_pkg::CNT_W'(1);
	assign read_next = read_pos_q + cbn_pkg::CNT_W'(1);
	assign chan_next = chan_idx_q + cbn_pkg::CH_W'(1);
	assign sum_next  = sum_q + 29'(item.sample);
	assign mean_mag  = {1'b0, div_quot[15:0]};
	assign mean_ext  = 17'(mean_q);

	// the one multiplier: square in the walk, gamma product on a read
	assign mul_a     = (state_q == S_WSQ) ? diff_q : 17'(gamma_q);
	assign prod_abs  = prod_q[33] ? -prod_q : prod_q;

	// signed quotient, offset and saturation
	always_comb begin
		quo_s = '0;
		if (std_q != '0) begin
			quo_s = neg_q ? -34'(div_quot[31:0]) : 34'(div_quot[31:0]);
		end
		r_full = 35'(quo_s) + 35'(beta_q);
		if (r_full > 35'sd32767) begin
			r_sat = 16'sh7fff;
		end else if (r_full < -35'sd32768) begin
			r_sat = -16'sh8000;
		end else begin
			r_sat = r_full[15:0];
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q  <= cbn_pkg::CNT_W'(cbn_pkg::MAX_ELEMENTS);
			chan_q  <= cbn_pkg::CHC_W'(1);
			gamma_q <= 16'sd256;
			beta_q  <= '0;
			eps_q   <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbn_pkg::CFG_ELEMENT_COUNT:     elem_q  <= cfg_data[cbn_pkg::CNT_W-1:0];
				cbn_pkg::CFG_CHANNEL_COUNT:     chan_q  <= cfg_data[cbn_pkg::CHC_W-1:0];
				cbn_pkg::CFG_SCALE_GAMMA:       gamma_q <= cfg_data;
				cbn_pkg::CFG_SHIFT_BETA:        beta_q  <= cfg_data;
				cbn_pkg::CFG_STABILITY_EPSILON: eps_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sample store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (accept && item.cmd == cbn_pkg::CMD_LOAD && !pending_q) begin
			mem[load_pos_q[cbn_pkg::ADDR_W-1:0]] <= item.sample;
		end
		rdata_q <= mem[addr_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			load_pos_q   <= '0;
			read_pos_q   <= '0;
			cnt_q        <= '0;
			idx_q        <= '0;
			sum_q        <= '0;
			mean_q       <= '0;
			std_q        <= '0;
			pending_q    <= 1'b0;
			chan_idx_q   <= '0;
			sq_q         <= '0;
			diff_q       <= '0;
			prod_q       <= '0;
			neg_q        <= 1'b0;
			addr_q       <= '0;
			div_req_q    <= '0;
			sqrt_start_q <= 1'b0;
			sqrt_rad_q   <= '0;
			done_q       <= 1'b0;
			result_q     <= '0;
		end else begin
			div_req_q.start <= 1'b0;
			sqrt_start_q    <= 1'b0;
			done_q          <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && item.cmd == cbn_pkg::CMD_LOAD && !pending_q) begin
						sum_q      <= sum_next;
						load_pos_q <= load_next;
						if (load_next >= eff_elem) begin
							cnt_q              <= load_next;
							div_req_q.start    <= 1'b1;
							div_req_q.dividend <= cbn_pkg::DIV_W'(sum_next[28] ?
							                      29'(-sum_next) : 29'(sum_next));
							div_req_q.divisor  <= cbn_pkg::DVS_W'(load_next);
							state_q            <= S_MEAN;
						end
					end else if (accept && item.cmd == cbn_pkg::CMD_READ && pending_q) begin
						addr_q  <= read_pos_q[cbn_pkg::ADDR_W-1:0];
						state_q <= S_RRD;
					end
				end
				S_MEAN: begin
					if (div_done) begin
						mean_q  <= sum_q[28] ? 16'(-mean_mag) : 16'(mean_mag);
						idx_q   <= '0;
						addr_q  <= '0;
						sq_q    <= '0;
						state_q <= S_WRD;
					end
				end
				S_WRD: state_q <= S_WDIF;
				S_WDIF: begin
					diff_q  <= 17'($signed(rdata_q)) - mean_ext;
					state_q <= S_WSQ;
				end
				S_WSQ: begin
					prod_q  <= 34'(mul_a * diff_q);
					state_q <= S_WACC;
				end
				S_WACC: begin
					sq_q  <= sq_q + cbn_pkg::DIV_W'(prod_q[32:0]);
					idx_q <= idx_next;
					if (idx_next == cnt_q) begin
						div_req_q.start    <= 1'b1;
						div_req_q.dividend <= sq_q + cbn_pkg::DIV_W'(prod_q[32:0]);
						div_req_q.divisor  <= cbn_pkg::DVS_W'(cnt_q);
						state_q            <= S_VAR;
					end else begin
						addr_q  <= idx_next[cbn_pkg::ADDR_W-1:0];
						state_q <= S_WRD;
					end
				end
				S_VAR: begin
					if (div_done) begin
						sqrt_start_q <= 1'b1;
						sqrt_rad_q   <= cbn_pkg::SQ_W'(div_quot[32:0]) +
						                cbn_pkg::SQ_W'(eps_q);
						state_q      <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						std_q      <= sqrt_root[15:0];
						pending_q  <= 1'b1;
						read_pos_q <= '0;
						state_q    <= S_IDLE;
					end
				end
				S_RRD: state_q <= S_RDIF;
				S_RDIF: begin
					diff_q  <= 17'($signed(rdata_q)) - mean_ext;
					state_q <= S_RMUL;
				end
				S_RMUL: begin
					prod_q  <= 34'(mul_a * diff_q);
					state_q <= S_RABS;
				end
				S_RABS: begin
					neg_q <= prod_q[33];
					if (std_q == '0) begin
						state_q <= S_ROUT;
					end else begin
						div_req_q.start    <= 1'b1;
						div_req_q.dividend <= cbn_pkg::DIV_W'(prod_abs[32:0]);
						div_req_q.divisor  <= std_q;
						state_q            <= S_RDIV;
					end
				end
				S_RDIV: begin
					if (div_done) begin
						state_q <= S_ROUT;
					end
				end
				S_ROUT: begin
					done_q                 <= 1'b1;
					result_q.norm_value    <= r_sat;
					result_q.channel_index <= chan_idx_q;
					result_q.channel_last  <= read_next >= eff_elem;
					if (read_next >= eff_elem) begin
						chan_idx_q <= ({1'b0, chan_next} >= eff_chan) ? '0 : chan_next;
						pending_q  <= 1'b0;
						read_pos_q <= '0;
						load_pos_q <= '0;
						sum_q      <= '0;
					end else begin
						read_pos_q <= read_next;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	cbn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	cbn_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start_q),
		.radicand (sqrt_rad_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	// a result beat only follows the output step
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_ROUT))
		else $error("result beat without output step");

	// a load beat while results are pending leaves the channel untouched
	a_load_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.cmd == cbn_pkg::CMD_LOAD && pending_q) |=>
		($stable(load_pos_q) && $stable(sum_q)))
		else $error("load accepted while results pending");

	// state register stays one-hot
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state not one-hot");
`endif

endmodule
